>>> rtl/core/u2d_pkg.sv
// ----------------------------------------------------------------------------
// Unsigned to decimal ASCII package
// Shared constants and the command and status types of the converter.
// ----------------------------------------------------------------------------
package u2d_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 6;
    localparam int BCD_W      = 4;
    localparam int BYTE_W     = 8;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic load;
        logic shift;
        logic advance;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic bits_done;
        logic top_zero;
        logic digits_one;
    } status_t;

endpackage

>>> rtl/core/u2d_if.sv
// ----------------------------------------------------------------------------
// Unsigned to decimal ASCII channels
// Valid/ready channels for input numbers and output digit items.
// ----------------------------------------------------------------------------
interface u2d_in_if;
    logic                         valid;
    logic                         ready;
    logic [u2d_pkg::VALUE_W-1:0]  value;
    logic                         byte_mode;

    modport source (output valid, output value, output byte_mode, input ready);
    modport sink   (input valid, input value, input byte_mode, output ready);
endinterface

interface u2d_out_if;
    logic                         valid;
    logic                         ready;
    logic [u2d_pkg::CHAR_W-1:0]   digit_char;
    logic                         last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

>>> rtl/core/unsigned_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// Sequence: a load, a shift for each of the VALUE_WIDTH bits (the low 8 in byte
//   mode), an advance per leading zero dropped and a step to leave the skip,
//   then a capture per digit; each digit item is valid the cycle after it is
//   captured. A new number is taken only when idle, after the last digit of
//   the one before is captured; output stalls hold the digit emission.
// Reset: asynchronous, clears controller state and counters; data is not reset.
// ----------------------------------------------------------------------------
// Unsigned to decimal ASCII core
// Converts an unsigned number into its decimal ASCII digits, one per item.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    u2d_in_if.sink     din,
    u2d_out_if.source  dout
);

    u2d_pkg::cmd_t    cmd;
    u2d_pkg::status_t status;

    u2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_ready (dout.ready),
        .status    (status),
        .cmd       (cmd)
    );

    u2d_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .value      (din.value),
        .byte_mode  (din.byte_mode),
        .digit_char (dout.digit_char),
        .last       (dout.last)
    );

`ifndef SYNTHESIS
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.shift, cmd.advance}))
        else $error("conflicting datapath commands");

    a_capture_advances: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> cmd.advance)
        else $error("digit captured without advancing");

    a_load_then_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> (cmd.shift && !din.ready))
        else $error("accepted item did not start conversion");
`endif

endmodule

>>> rtl/core/u2d_datapath.sv
// ----------------------------------------------------------------------------
// Unsigned to decimal ASCII datapath
// Bit-serial double-dabble shifter, BCD digit register and output register.
// ----------------------------------------------------------------------------
module u2d_datapath #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  u2d_pkg::cmd_t                 cmd,
    output u2d_pkg::status_t              status,
    input  logic [u2d_pkg::VALUE_W-1:0]   value,
    input  logic                          byte_mode,
    output logic [u2d_pkg::CHAR_W-1:0]    digit_char,
    output logic                          last
);

    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    logic [VALUE_WIDTH-1:0]         bin_reg;
    logic [VALUE_WIDTH-1:0]         bin_next;
    logic [BIT_CNT_W-1:0]           bit_cnt_reg;
    logic [BIT_CNT_W-1:0]           bit_cnt_next;
    logic [DIG_CNT_W-1:0]           dig_cnt_reg;
    logic [DIG_CNT_W-1:0]           dig_cnt_next;
    logic [u2d_pkg::BCD_W-1:0]      bcd_reg  [NUM_DIGITS];
    logic [u2d_pkg::BCD_W-1:0]      bcd_next [NUM_DIGITS];
    logic [u2d_pkg::BCD_W-1:0]      adj      [NUM_DIGITS];
    logic [u2d_pkg::CHAR_W-1:0]     char_reg;
    logic                           last_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_next[i] = bcd_reg[i];
        end
        if (cmd.load)
        begin
            if (byte_mode)
            begin
                bin_next     = VALUE_WIDTH'(value[u2d_pkg::BYTE_W-1:0])
                               << (VALUE_WIDTH - u2d_pkg::BYTE_W);
                bit_cnt_next = BIT_CNT_W'(u2d_pkg::BYTE_W);
            end
            else
            begin
                bin_next     = value[VALUE_WIDTH-1:0];
                bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
            end
            dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                bcd_next[i] = '0;
            end
        end
        else if (cmd.shift)
        begin
            bin_next     = bin_reg << 1;
            bit_cnt_next = bit_cnt_reg - 1'b1;
            bcd_next[0]  = {adj[0][2:0], bin_reg[VALUE_WIDTH-1]};
            for (int i = 1; i < NUM_DIGITS; i++)
            begin
                bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end
        else if (cmd.advance)
        begin
            dig_cnt_next = dig_cnt_reg - 1'b1;
            bcd_next[0]  = '0;
            for (int i = 1; i < NUM_DIGITS; i++)
            begin
                bcd_next[i] = bcd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_reg[i] <= bcd_next[i];
        end
        if (cmd.capture)
        begin
            char_reg <= u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_W'(bcd_reg[NUM_DIGITS-1]);
            last_reg <= (dig_cnt_reg == DIG_CNT_W'(1));
        end
    end

    assign status.bits_done  = (bit_cnt_reg == BIT_CNT_W'(1));
    assign status.top_zero   = (bcd_reg[NUM_DIGITS-1] == '0);
    assign status.digits_one = (dig_cnt_reg == DIG_CNT_W'(1));
    assign digit_char        = char_reg;
    assign last              = last_reg;

endmodule

>>> rtl/core/u2d_ctrl.sv
// ----------------------------------------------------------------------------
// Unsigned to decimal ASCII controller
// Sequences load, conversion, leading-zero skip and digit emission.
// ----------------------------------------------------------------------------
module u2d_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  u2d_pkg::status_t   status,
    output u2d_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
                if (status.bits_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (status.top_zero && !status.digits_one)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.capture = 1'b1;
                    cmd.advance = 1'b1;
                    if (status.digits_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> bench/u2d_digit_checker.sv
// ----------------------------------------------------------------------------
// Unsigned to decimal ASCII digit checker
// Watches both channels of the converter. Each accepted number is expanded
// into its expected decimal digit items, most significant digit first. Each
// accepted digit item is compared field by field with the oldest expected
// item. The failure count and the number of outstanding digits are passed
// to the testbench top.
// ----------------------------------------------------------------------------
module u2d_digit_checker #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    u2d_in_if    num_ch,
    u2d_out_if   dig_ch,
    output int   errors,
    output int   outstanding
);

    localparam int MAX_DIGITS = 20;
    localparam logic [u2d_pkg::VALUE_W-1:0] WIDTH_MASK =
        (VALUE_WIDTH >= u2d_pkg::VALUE_W) ? {u2d_pkg::VALUE_W{1'b1}}
                                           : ((64'd1 << VALUE_WIDTH) - 64'd1);

    typedef struct packed {
        logic [u2d_pkg::CHAR_W-1:0] char_code;
        logic                       last;
    } digit_t;

    digit_t expected_digits[$];
    digit_t head;

    initial errors = 0;

    task automatic report(input string msg);
        $display("%0t: digit check: %s", $time, msg);
        errors++;
    endtask

    function automatic void queue_decimal_text(input logic [u2d_pkg::VALUE_W-1:0] value,
                                               input logic byte_mode);
        logic [u2d_pkg::VALUE_W-1:0] num;
        logic [u2d_pkg::BCD_W-1:0]   rev [MAX_DIGITS];
        int                          count;
        digit_t                      d;
        num   = byte_mode ? (value & 64'hFF) : (value & WIDTH_MASK);
        count = 0;
        do
        begin
            rev[count] = u2d_pkg::BCD_W'(num % 64'd10);
            num        = num / 64'd10;
            count++;
        end
        while (num != 0 && count < MAX_DIGITS);
        for (int k = 0; k < count; k++)
        begin
            d.char_code = u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_W'(rev[count-1-k]);
            d.last      = (k == count - 1);
            expected_digits.push_back(d);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_digits.delete();
            outstanding <= 0;
        end
        else
        begin
            if (dig_ch.valid && dig_ch.ready)
            begin
                if (expected_digits.size() == 0)
                    report($sformatf("unexpected digit item char=%0d last=%0d",
                                     dig_ch.digit_char, dig_ch.last));
                else
                begin
                    head = expected_digits.pop_front();
                    if (dig_ch.digit_char !== head.char_code)
                        report($sformatf("digit_char got %0d want %0d",
                                         dig_ch.digit_char, head.char_code));
                    if (dig_ch.last !== head.last)
                        report($sformatf("last got %0d want %0d (char %0d)",
                                         dig_ch.last, head.last, head.char_code));
                end
            end
            if (num_ch.valid && num_ch.ready)
                queue_decimal_text(num_ch.value, num_ch.byte_mode);
            outstanding <= expected_digits.size();
        end
    end

endmodule

>>> bench/unsigned_to_decimal_ascii_core_tb.sv
// ----------------------------------------------------------------------------
// Unsigned to decimal ASCII core testbench
// Offers directed corner numbers, then random numbers in bursts with random
// gaps, while the digit receiver stalls on its own pattern and once holds
// off long enough to back up the converter. A separate checker predicts and
// compares every digit item; this top gives the verdict.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_core_tb;

    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_ITEM    = 100;
    localparam int DRAIN_ITEM   = 180;
    localparam int TAIL_CYCLES  = 200;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   outstanding;
    bit   hold_req;
    bit   no_gaps;
    int   burst_left;
    int   hold_left;
    int   run_left;
    int   rx_mode;

    u2d_in_if  num_ch ();
    u2d_out_if dig_ch ();

    unsigned_to_decimal_ascii_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (num_ch),
        .dout  (dig_ch)
    );

    u2d_digit_checker digit_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_ch      (num_ch),
        .dig_ch      (dig_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("unsigned_to_decimal_ascii_core_tb: errors");
        $finish;
    end

    function automatic logic [u2d_pkg::VALUE_W-1:0] pow10(input int n);
        logic [u2d_pkg::VALUE_W-1:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [u2d_pkg::VALUE_W-1:0] pick_value();
        logic [u2d_pkg::VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: ;
            2: v = v >> $urandom_range(0, 63);
            3: v = 64'($urandom_range(0, 999));
            4: v = pow10($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
            default: v = {u2d_pkg::VALUE_W{1'b1}} - 64'($urandom_range(0, 20));
        endcase
        return v;
    endfunction

    // hand over one number, then keep the burst going or idle for a while
    task automatic offer(input logic [u2d_pkg::VALUE_W-1:0] v, input logic bm);
        int gap;
        num_ch.valid     <= 1'b1;
        num_ch.value     <= v;
        num_ch.byte_mode <= bm;
        @(posedge clk);
        while (!num_ch.ready)
            @(posedge clk);
        if (no_gaps)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 15);
            num_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic drain();
        num_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // digit receiver: own stall pattern, plus one long hold on request
    initial
    begin
        dig_ch.ready <= 1'b0;
        hold_left = 0;
        run_left  = 0;
        rx_mode   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                dig_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                dig_ch.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    rx_mode  = $urandom_range(0, 3);
                    run_left = $urandom_range(5, 80);
                end
                run_left--;
                case (rx_mode)
                    0: dig_ch.ready <= 1'b1;
                    1: dig_ch.ready <= ($urandom_range(0, 1) == 0);
                    2: dig_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: dig_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [u2d_pkg::VALUE_W-1:0] v;
        int                          wait_cycles;
        rst_n            <= 1'b0;
        num_ch.valid     <= 1'b0;
        num_ch.value     <= '0;
        num_ch.byte_mode <= 1'b0;
        hold_req   = 1'b0;
        no_gaps    = 1'b0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(64'd0, 1'b0);
        offer(64'd0, 1'b1);
        offer(64'd1, 1'b0);
        offer(64'd9, 1'b0);
        offer(64'd10, 1'b0);
        offer(64'd99, 1'b1);
        offer(64'd100, 1'b1);
        offer(64'd255, 1'b1);
        offer(64'd256, 1'b1);
        offer({u2d_pkg::VALUE_W{1'b1}}, 1'b1);
        offer({u2d_pkg::VALUE_W{1'b1}}, 1'b0);
        offer(pow10(19), 1'b0);
        offer(pow10(19) - 64'd1, 1'b0);
        offer(pow10(18), 1'b0);
        offer(64'h8000_0000_0000_0000, 1'b0);
        offer(64'h8000_0000_0000_0000, 1'b1);
        offer(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        offer(64'h5555_5555_5555_5555, 1'b1);
        offer(64'd123456789, 1'b0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_ITEM)
            begin
                hold_req = 1'b1;
                no_gaps  = 1'b1;
            end
            if (i == HOLD_ITEM + 30)
                no_gaps = 1'b0;
            if (i == DRAIN_ITEM)
                drain();
            v = pick_value();
            offer(v, $urandom_range(0, 3) == 0);
        end
        num_ch.valid <= 1'b0;

        @(posedge clk);
        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 200_000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("unsigned_to_decimal_ascii_core_tb: clean");
        else
            $display("unsigned_to_decimal_ascii_core_tb: errors");
        $finish;
    end

endmodule
